// ===== rtl/xmpr_pkg.sv =====
package xmpr_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] RESET_A = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [WordW-1:0] RESET_B = 64'hCAFE_F00D_D15E_A5E5;

  // rotate and shift amounts of the generator
  localparam int unsigned ROT_OUT  = 7;
  localparam int unsigned ROT_A    = 45;
  localparam int unsigned SHIFT_B  = 17;

  // divider iteration count and counter width
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  // command codes; 5 to 7 are ignored
  localparam logic [2:0] CMD_RAW    = 3'd0;
  localparam logic [2:0] CMD_URANGE = 3'd1;
  localparam logic [2:0] CMD_SRANGE = 3'd2;
  localparam logic [2:0] CMD_RESEED = 3'd3;
  localparam logic [2:0] CMD_SETA   = 3'd4;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [WordW-1:0] bound_low;
    logic [WordW-1:0] bound_high;
    logic [WordW-1:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             bad_range;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic draw;
    logic seed_a;
    logic reset_b;
    logic rot;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_draw;
    logic is_raw;
    logic is_reseed;
    logic is_seta;
    logic bad;
    logic span_zero;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_ROT    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

// ===== rtl/xmpr_ctrl.sv =====
module xmpr_ctrl
  import xmpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_draw) begin
          cmd.draw  = 1'b1;
          state_nxt = ST_ROT;
        end else begin
          cmd.seed_a  = stat.is_reseed | stat.is_seta;
          cmd.reset_b = stat.is_reseed;
          state_nxt   = ST_IDLE;
        end
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (stat.is_raw || stat.bad || stat.span_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/xmpr_dp.sv =====
module xmpr_dp
  import xmpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // generator state
  logic [WordW-1:0] word_a_r, word_b_r;
  // captured item
  logic [2:0]       cmd_r;
  logic [WordW-1:0] lo_r, hi_r, seed_r;
  // draw and range work
  logic [WordW-1:0] m5_r, raw_r, span_r, dvd_r, rem_r;
  logic             bad_r;
  logic [CntW-1:0]  cnt_r;
  // output register
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             is_draw, is_raw, is_range, is_signed, is_reseed, is_seta;
  logic [WordW-1:0] t_b, b1, a1, b2, rot_m5, raw_nxt;
  logic [WordW:0]   partial;
  logic [WordW+1:0] diff;
  logic [WordW-1:0] off, sum;
  out_item_t        res;

  always_comb begin
    is_raw    = 1'b0;
    is_range  = 1'b0;
    is_signed = 1'b0;
    is_reseed = 1'b0;
    is_seta   = 1'b0;
    unique case (cmd_r)
      CMD_RAW:    is_raw    = 1'b1;
      CMD_URANGE: is_range  = 1'b1;
      CMD_SRANGE: begin
        is_range  = 1'b1;
        is_signed = 1'b1;
      end
      CMD_RESEED: is_reseed = 1'b1;
      CMD_SETA:   is_seta   = 1'b1;
      default:    ;
    endcase
    is_draw = is_raw | is_range;
  end

  // state advance
  assign t_b = word_b_r << SHIFT_B;
  assign b1  = word_b_r ^ word_a_r;
  assign a1  = word_a_r ^ b1;
  assign b2  = b1 ^ t_b;

  // output scramble: rotl(a*5, 7) * 9, with a*5 registered in m5_r
  assign rot_m5  = {m5_r[WordW-1-ROT_OUT:0], m5_r[WordW-1:WordW-ROT_OUT]};
  assign raw_nxt = {rot_m5[WordW-4:0], 3'b000} + rot_m5;

  // restoring remainder step
  assign partial = {rem_r, dvd_r[WordW-1]};
  assign diff    = {1'b0, partial} - {2'b00, span_r};

  assign off = (span_r == '0) ? raw_r : rem_r;
  assign sum = lo_r + off;

  always_comb begin
    if (is_raw) begin
      res.value     = raw_r;
      res.bad_range = 1'b0;
    end else if (bad_r) begin
      res.value     = lo_r;
      res.bad_range = 1'b1;
    end else begin
      res.value     = sum;
      res.bad_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r <= RESET_A;
      word_b_r <= RESET_B;
    end else if (cmd.draw) begin
      word_a_r <= {a1[WordW-1-ROT_A:0], a1[WordW-1:WordW-ROT_A]};
      word_b_r <= b2;
    end else begin
      if (cmd.seed_a) word_a_r <= seed_r;
      if (cmd.reset_b) word_b_r <= RESET_B;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_data.cmd;
      lo_r   <= in_data.bound_low;
      hi_r   <= in_data.bound_high;
      seed_r <= in_data.seed_value;
    end
    if (cmd.draw) begin
      m5_r   <= {word_a_r[WordW-3:0], 2'b00} + word_a_r;
      span_r <= hi_r - lo_r + {{(WordW-1){1'b0}}, 1'b1};
      bad_r  <= is_signed ? ($signed(hi_r) < $signed(lo_r)) : (hi_r < lo_r);
    end
    if (cmd.rot) begin
      raw_r <= raw_nxt;
      dvd_r <= raw_nxt;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[WordW-2:0], 1'b0};
      rem_r <= diff[WordW+1] ? partial[WordW-1:0] : diff[WordW-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.is_draw   = is_draw;
  assign stat.is_raw    = is_raw;
  assign stat.is_reseed = is_reseed;
  assign stat.is_seta   = is_seta;
  assign stat.bad       = bad_r;
  assign stat.span_zero = (span_r == '0);
  assign stat.div_last  = (cnt_r == CntW'(DivSteps - 1));
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== rtl/xorshift_multiply_prng_with_range.sv =====
// Sequence: raw draws, out-of-order bounds and full spans pass capture, decode/advance,
// scramble and result; ranged draws with a nonzero span also run the bit-serial remainder unit.
// One item at a time: in_stall stays high until the controller is back in idle, which
// follows decode for seed and unused commands and the result load for draws.
// Reset (rst_n low, synchronous): word_a = 0xDEADBEEFCAFEBABE, word_b = 0xCAFEF00DD15EA5E5,
// controller idle, output register empty.
module xorshift_multiply_prng_with_range
  import xmpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Control/datapath split:
  //   xmpr_ctrl sequences capture -> decode/advance -> scramble -> divide -> result.
  //   xmpr_dp holds the generator words, the scramble registers, the
  //   restoring remainder unit and the output register.
  // The output register lets a new item transfer in while a finished
  // result is still stalled on the out side.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  xmpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Draw: word_a*5 captured with the state advance, then rotl by 7 and *9
  // as shift-and-add in the next cycle. Ranged draws with a nonzero span
  // run 64 remainder steps; full span adds the raw word to the low bound.
  xmpr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/xmpr_chk.sv =====
module xmpr_chk
  import xmpr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // no result too soon after a transfer in
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too early");

  // a new result appears only as the controller returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind xorshift_multiply_prng_with_range xmpr_chk u_chk (.*);

// ===== test/testbench.sv =====
module testbench;
  import xmpr_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int RANDOM_ITEMS   = 975;   // random draws/seeds, ignored codes not counted
  localparam int CHUNK          = 130;   // items per traffic phase
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 100;   // extra wait after the expectation queue empties
  localparam int MAX_REPORTS    = 10;
  localparam int BUSY_PCT       = 47;
  localparam int LIGHT_PCT      = 7;

  localparam logic [WordW-1:0] ALL_ONES = '1;
  localparam logic [WordW-1:0] SMIN     = 64'h8000_0000_0000_0000;
  localparam logic [WordW-1:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum int {
    TRAFFIC_STEADY,        // neither side idles
    TRAFFIC_SEND_GAPS,     // sender idle in about half the cycles
    TRAFFIC_RECV_STALLS,   // receiver stalls about half the cycles
    TRAFFIC_BOTH           // both sides, lightly
  } traffic_t;

  // directed stimulus row; fixed rows carry an expectation typed in by hand
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  xorshift_multiply_prng_with_range i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Generator copy and expected results
  // ---------------------------------------------------------------------------
  logic [WordW-1:0] gen_a;
  logic [WordW-1:0] gen_b;
  out_item_t        pending_draws[$];
  dir_row_t         dir_rows[$];

  traffic_t traffic       = TRAFFIC_STEADY;
  int       hold_requests = 0;
  int       mismatch_count = 0;
  int       n_raw = 0, n_ranged = 0, n_bad = 0, n_seed = 0, n_ignored = 0, n_checked = 0;

  function automatic logic [WordW-1:0] rotl64(logic [WordW-1:0] v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // one generator step: returns the scrambled word, advances both state words
  function automatic logic [WordW-1:0] draw_word();
    logic [WordW-1:0] raw;
    logic [WordW-1:0] t;
    raw   = gen_a * 64'd5;
    raw   = rotl64(raw, ROT_OUT) * 64'd9;
    t     = gen_b << SHIFT_B;
    gen_b = gen_b ^ gen_a;
    gen_a = gen_a ^ gen_b;
    gen_b = gen_b ^ t;
    gen_a = rotl64(gen_a, ROT_A);
    return raw;
  endfunction

  // applies one accepted command to the generator copy; 1 when a result follows
  function automatic bit predict_step(input in_item_t it, output out_item_t res);
    logic [WordW-1:0] raw;
    logic [WordW-1:0] span;
    bit               produced;
    res      = '0;
    produced = 1'b0;
    case (it.cmd) inside
      CMD_RAW: begin
        res.value = draw_word();
        produced  = 1'b1;
      end
      CMD_URANGE, CMD_SRANGE: begin
        // the draw is taken even for an out-of-order range
        raw = draw_word();
        if (it.cmd == CMD_URANGE) begin
          res.bad_range = it.bound_high < it.bound_low;
        end else begin
          res.bad_range = $signed(it.bound_high) < $signed(it.bound_low);
        end
        if (res.bad_range) begin
          res.value = it.bound_low;
        end else begin
          span      = it.bound_high - it.bound_low + 64'd1;
          // span wraps to zero on the full 64-bit range: offset is the raw word
          res.value = it.bound_low + ((span == '0) ? raw : raw % span);
        end
        produced = 1'b1;
      end
      CMD_RESEED: begin
        gen_a = it.seed_value;
        gen_b = RESET_B;
      end
      CMD_SETA: begin
        gen_a = it.seed_value;
      end
      default: ;  // unused codes leave the state alone
    endcase
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [WordW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit sender_idles();
    case (traffic)
      TRAFFIC_SEND_GAPS: return $urandom_range(0, 99) < BUSY_PCT;
      TRAFFIC_BOTH:      return $urandom_range(0, 99) < LIGHT_PCT;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (traffic)
      TRAFFIC_RECV_STALLS: return $urandom_range(0, 99) < BUSY_PCT;
      TRAFFIC_BOTH:        return $urandom_range(0, 99) < LIGHT_PCT;
      default:             return 1'b0;
    endcase
  endfunction

  task automatic add_row(logic [2:0] c, logic [WordW-1:0] lo, logic [WordW-1:0] hi,
                         logic [WordW-1:0] seed, bit fixed = 1'b0,
                         logic [WordW-1:0] v = '0, bit bad = 1'b0);
    dir_row_t r;
    r.item.cmd          = c;
    r.item.bound_low    = lo;
    r.item.bound_high   = hi;
    r.item.seed_value   = seed;
    r.fixed             = fixed;
    r.want.value        = v;
    r.want.bad_range    = bad;
    dir_rows.push_back(r);
  endtask

  // mostly well-formed ranges with random content, some fully random bounds
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned shape;
    int          sv;
    it.bound_low  = rand64();
    it.bound_high = rand64();
    it.seed_value = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 25)      it.cmd = CMD_RAW;
    else if (pick < 55) it.cmd = CMD_URANGE;
    else if (pick < 85) it.cmd = CMD_SRANGE;
    else if (pick < 90) it.cmd = CMD_RESEED;
    else if (pick < 95) it.cmd = CMD_SETA;
    else                it.cmd = CMD_SETA + 3'($urandom_range(1, 3));
    shape = $urandom_range(0, 99);
    if (shape < 45) begin
      it.bound_high = it.bound_low + 64'($urandom_range(0, 1000));
    end else if (shape < 60) begin
      // small window around zero, exercises the signed compare
      sv            = int'($urandom_range(0, 1000)) - 500;
      it.bound_low  = {{32{sv[31]}}, sv};
      it.bound_high = it.bound_low + 64'($urandom_range(0, 1000));
    end else if (shape < 70) begin
      it.bound_high = it.bound_low + (rand64() >> $urandom_range(1, 63));
    end else if (shape < 75) begin
      it.bound_high = it.bound_low - 64'd1;  // full span
    end else if (shape < 80) begin
      it.bound_high = it.bound_low;
    end
    return it;
  endfunction

  // offer one item, hold it until the transfer, then update the prediction
  task automatic send_item(in_item_t it, bit fixed, out_item_t want);
    out_item_t res;
    bit        produced;
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = predict_step(it, res);
    if (produced) pending_draws.push_back(fixed ? want : res);
    case (it.cmd) inside
      CMD_RAW:                n_raw++;
      CMD_URANGE, CMD_SRANGE: begin
        n_ranged++;
        if (res.bad_range) n_bad++;
      end
      CMD_RESEED, CMD_SETA:   n_seed++;
      default:                n_ignored++;
    endcase
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: %s: expected value %h bad_range %b, got value %h bad_range %b",
               $time, what, want.value, want.bad_range, got.value, got.bad_range);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int holds_served;
    holds_served = 0;
    @(posedge clk);
    forever begin
      if (hold_requests > holds_served) begin
        holds_served++;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= receiver_stalls();
        @(posedge clk);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = pending_draws.pop_front();
        if (out_data.value !== want.value || out_data.bad_range !== want.bad_range) begin
          report_mismatch("result mismatch", want, out_data);
        end
        n_checked++;
      end
    end
  end

  // no transfer on either channel for too long: the block is stuck
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, pending_draws.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t  it;
    out_item_t no_fix;
    int        sent;
    int        next_hold_at;

    no_fix = '0;

    // directed table: extremes, every command, each special case
    add_row(CMD_RAW,    '0, '0, '0);                       // first draw after reset
    add_row(CMD_RAW,    ALL_ONES, ALL_ONES, ALL_ONES);
    add_row(CMD_URANGE, '0, ALL_ONES, '0);                 // full unsigned span
    add_row(CMD_SRANGE, SMIN, SMAX, '0);                   // full signed span
    add_row(CMD_URANGE, 64'd5, 64'd4, '0, 1'b1, 64'd5, 1'b1);
    add_row(CMD_URANGE, ALL_ONES, '0, '0, 1'b1, ALL_ONES, 1'b1);
    add_row(CMD_SRANGE, 64'd1, ALL_ONES, '0, 1'b1, 64'd1, 1'b1);  // -1 below 1
    add_row(CMD_SRANGE, SMAX, SMIN, '0, 1'b1, SMAX, 1'b1);
    add_row(CMD_SRANGE, ALL_ONES, 64'd1, '0);              // fine signed, bad unsigned
    add_row(CMD_URANGE, '0, '0, '0, 1'b1, '0, 1'b0);       // single-value range
    add_row(CMD_URANGE, ALL_ONES, ALL_ONES, '0, 1'b1, ALL_ONES, 1'b0);
    add_row(CMD_URANGE, '0, 64'd1, '0);
    add_row(CMD_URANGE, 64'd100, 64'd199, '0);
    add_row(CMD_RESEED, ALL_ONES, ALL_ONES, '0);           // zero first word
    add_row(CMD_RAW,    '0, '0, '0);
    add_row(CMD_RAW,    '0, '0, '0);
    add_row(CMD_SETA,   '0, '0, ALL_ONES);
    add_row(CMD_RAW,    '0, '0, '0);
    add_row(CMD_SETA + 3'd1, ALL_ONES, '0, 64'h1234);      // unused codes
    add_row(CMD_SETA + 3'd2, '0, ALL_ONES, 64'h5678);
    add_row(CMD_SETA + 3'd3, ALL_ONES, ALL_ONES, ALL_ONES);
    add_row(CMD_RAW,    '0, '0, '0);
    add_row(CMD_RESEED, '0, '0, 64'h0123_4567_89AB_CDEF);
    add_row(CMD_SRANGE, -64'sd10, 64'sd10, '0);
    add_row(CMD_URANGE, '0, SMAX, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    gen_a = RESET_A;
    gen_b = RESET_B;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

    // random part; traffic phase rotates every CHUNK items, and every
    // steady phase starts with a long receiver hold-off so the input backs up
    sent         = 0;
    next_hold_at = 0;
    while (sent < RANDOM_ITEMS) begin
      traffic = traffic_t'((sent / CHUNK) % 4);
      if (sent == next_hold_at) begin
        hold_requests++;
        next_hold_at += 4 * CHUNK;
      end
      it = random_item();
      send_item(it, 1'b0, no_fix);
      if (it.cmd <= CMD_SETA) sent++;
    end
    in_valid <= 1'b0;
    traffic = TRAFFIC_STEADY;

    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_draws.size();

    $display("ran %0d raw draws, %0d ranged draws (%0d out of order), %0d seed loads, %0d ignored",
             n_raw, n_ranged, n_bad, n_seed, n_ignored);
    $display("%0d results compared, %0d mismatches, under four traffic patterns",
             n_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xmpr_pkg.sv
rtl/xmpr_ctrl.sv
rtl/xmpr_dp.sv
rtl/xorshift_multiply_prng_with_range.sv
rtl/xmpr_chk.sv
test/testbench.sv
